// File: sv/sega_pkg.sv
// ----------------------------------------------------------------------------
// sega_pkg
// Shared types and constants for the segment allocator.
// ----------------------------------------------------------------------------
package sega_pkg;

   localparam int MaxSegments = 16;
   localparam int MemoryWords = 1024;
   localparam int TagBits     = 8;

   localparam int IdxBits  = $clog2(MaxSegments);
   localparam int CntBits  = $clog2(MaxSegments + 1);
   localparam int BaseBits = 10;
   localparam int LenBits  = 11;

   typedef logic [IdxBits-1:0]  idx_type;
   typedef logic [CntBits-1:0]  cnt_type;
   typedef logic [BaseBits-1:0] base_type;
   typedef logic [LenBits-1:0]  len_type;
   typedef logic [TagBits-1:0]  tag_type;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_MERGE = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] POL_FIRST   = 2'd0;
   localparam logic [1:0] POL_BEST    = 2'd1;
   localparam logic [1:0] POL_WORST   = 2'd2;
   localparam logic [1:0] POL_UNKNOWN = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_NOOWN  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_MERGE, S_DONE
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic    load;       // capture request, reset scan
      logic    scan_step;  // examine the entry under the pointer
      logic    commit;     // apply alloc/free result for the picked entry
      logic    shift_step; // move one entry up during a split
      logic    split;      // write the split pair
      logic    merge_step; // one merge-walk step
      logic    set_rsp;    // latch status/base
      logic [1:0] rsp_status;
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic    scan_last;  // pointer is at the last entry to examine
      logic    found;      // a candidate has been picked
      logic    need_split; // picked length exceeds request
      logic    table_full;
      logic    shift_done; // shift pointer reached pick + 1
      logic    merge_done;
   } stat_type;

endpackage

// File: sv/sega_datapath.sv
// ----------------------------------------------------------------------------
// sega_datapath
// Segment table, scan pointer, pick tracking and split/merge movers.
// ----------------------------------------------------------------------------
module sega_datapath import sega_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [1:0] opcode,
   input  tag_type    owner_tag,
   input  len_type    request_size,
   input  logic [1:0] fit_policy,
   output logic [1:0] status,
   output base_type   granted_base
);

   // table; owner is kept without reset
   base_type base_ff [MaxSegments];
   len_type  len_ff  [MaxSegments];
   logic     used_ff [MaxSegments];
   tag_type  own_ff  [MaxSegments];
   cnt_type  count_ff;

   logic [1:0] op_ff;
   tag_type    tag_ff;
   len_type    req_ff;
   logic [1:0] pol_ff;
   cnt_type    ptr_ff;    // scan / shift / merge pointer
   idx_type    pick_ff;
   logic       found_ff;
   logic [1:0] status_ff;
   base_type   gbase_ff;

   idx_type  pi;
   idx_type  pk1;
   logic     cand;
   logic     better;
   logic     owner_hit;
   logic     pair_free;

   assign pi  = ptr_ff[IdxBits-1:0];
   assign pk1 = pick_ff + idx_type'(1);

   // candidate test for the entry under the pointer
   always_comb begin
      owner_hit = used_ff[pi] && own_ff[pi] == tag_ff;
      cand      = !used_ff[pi] && len_ff[pi] >= req_ff;
      better    = !found_ff ||
                  (pol_ff == POL_BEST  && len_ff[pi] < len_ff[pick_ff]) ||
                  (pol_ff == POL_WORST && len_ff[pi] > len_ff[pick_ff]);
      pair_free = !used_ff[pi] && !used_ff[pi + idx_type'(1)];
   end

   // status to controller
   always_comb begin
      stat.scan_last  = (ptr_ff + cnt_type'(1) >= count_ff);
      stat.found      = found_ff;
      stat.need_split = len_ff[pick_ff] > req_ff;
      stat.table_full = count_ff >= cnt_type'(MaxSegments);
      stat.shift_done = ptr_ff <= cnt_type'(pk1) || pick_ff == idx_type'(MaxSegments-1);
      stat.merge_done = (ptr_ff + cnt_type'(1) >= count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxSegments; i++) begin
            base_ff[i] <= '0;
            len_ff[i]  <= '0;
            used_ff[i] <= 1'b0;
         end
         len_ff[0]  <= len_type'(MemoryWords);
         count_ff   <= cnt_type'(1);
         ptr_ff     <= '0;
         found_ff   <= 1'b0;
         pick_ff    <= '0;
         status_ff  <= ST_OK;
         gbase_ff   <= '0;
      end else begin
         if (cmd.load) begin
            op_ff    <= opcode;
            tag_ff   <= owner_tag;
            req_ff   <= request_size;
            pol_ff   <= fit_policy;
            ptr_ff   <= '0;
            found_ff <= 1'b0;
            pick_ff  <= '0;
         end
         // scan: first/best/worst fit or owner search
         if (cmd.scan_step) begin
            if (op_ff == OP_FREE) begin
               if (owner_hit && !found_ff) begin
                  found_ff <= 1'b1;
                  pick_ff  <= pi;
               end
            end else if (cand && better && !(found_ff && pol_ff == POL_FIRST)) begin
               found_ff <= 1'b1;
               pick_ff  <= pi;
            end
            ptr_ff <= ptr_ff + cnt_type'(1);
         end
         if (cmd.commit) begin
            used_ff[pick_ff] <= (op_ff == OP_ALLOC);
            if (op_ff == OP_ALLOC) own_ff[pick_ff] <= tag_ff;
            ptr_ff <= count_ff;
         end
         // split: move entries up one at a time, top first
         if (cmd.shift_step) begin
            base_ff[pi] <= base_ff[pi - idx_type'(1)];
            len_ff[pi]  <= len_ff[pi - idx_type'(1)];
            used_ff[pi] <= used_ff[pi - idx_type'(1)];
            own_ff[pi]  <= own_ff[pi - idx_type'(1)];
            ptr_ff      <= ptr_ff - cnt_type'(1);
         end
         if (cmd.split) begin
            base_ff[pk1] <= base_ff[pick_ff] + base_type'(req_ff);
            len_ff[pk1]  <= len_ff[pick_ff] - req_ff;
            used_ff[pk1] <= 1'b0;
            len_ff[pick_ff] <= req_ff;
            count_ff <= count_ff + cnt_type'(1);
         end
         // merge: fold entry i+1 into i one shift at a time
         if (cmd.merge_step) begin
            if (pair_free) begin
               len_ff[pi] <= len_ff[pi] + len_ff[pi + idx_type'(1)];
               for (int j = 0; j < MaxSegments - 1; j++) begin
                  if (j > int'(pi)) begin
                     base_ff[j] <= base_ff[j+1];
                     len_ff[j]  <= len_ff[j+1];
                     used_ff[j] <= used_ff[j+1];
                     own_ff[j]  <= own_ff[j+1];
                  end
               end
               base_ff[MaxSegments-1] <= '0;
               len_ff[MaxSegments-1]  <= '0;
               used_ff[MaxSegments-1] <= 1'b0;
               count_ff <= count_ff - cnt_type'(1);
            end else begin
               ptr_ff <= ptr_ff + cnt_type'(1);
            end
         end
         // base only on an ok allocate; an unused opcode answers in its load cycle
         if (cmd.set_rsp) begin
            status_ff <= cmd.rsp_status;
            gbase_ff  <= (cmd.rsp_status == ST_OK && op_ff == OP_ALLOC && !cmd.load) ?
                         base_ff[pick_ff] : '0;
         end
      end
   end

   assign status       = status_ff;
   assign granted_base = gbase_ff;

endmodule

// File: sv/sega_ctrl.sv
// ----------------------------------------------------------------------------
// sega_ctrl
// Sequencer: scan, decide, split shift or merge walk, then respond.
// ----------------------------------------------------------------------------
module sega_ctrl import sega_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [1:0] pol,
   input  len_type    req_size,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       bad_ff, bad_in;   // unknown policy or zero size

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_ALLOC;
         bad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         bad_ff   <= bad_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      bad_in    = bad_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_opcode;
               bad_in   = (pol == POL_UNKNOWN) || (req_size == '0);
               if (req_opcode == OP_MERGE) state_in = S_MERGE;
               else if (req_opcode == OP_ALLOC || req_opcode == OP_FREE) state_in = S_SCAN;
               else begin
                  cmd.set_rsp = 1'b1;
                  state_in    = S_DONE;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.set_rsp = 1'b1;
            state_in    = S_DONE;
            if (op_ff == OP_FREE) begin
               cmd.rsp_status = stat.found ? ST_OK : ST_NOOWN;
               cmd.commit     = stat.found;
            end else if (bad_ff || !stat.found) begin
               cmd.rsp_status = ST_NOFIT;
            end else if (stat.need_split && stat.table_full) begin
               cmd.rsp_status = ST_FULL;
            end else begin
               cmd.rsp_status = ST_OK;
               cmd.commit     = 1'b1;
               if (stat.need_split) begin
                  cmd.set_rsp = 1'b0;
                  state_in    = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            cmd.rsp_status = ST_OK;
            if (stat.shift_done) begin
               cmd.split   = 1'b1;
               cmd.set_rsp = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_MERGE: begin
            if (stat.merge_done) begin
               cmd.set_rsp = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.merge_step = 1'b1;
            end
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // a response is only shown after an item was taken
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("rsp while accepting");
   a_split_full: assert property (@(posedge clock) disable iff (reset)
      cmd.split |-> !stat.table_full) else $error("split on full table");
   a_one_move: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.shift_step, cmd.split, cmd.merge_step, cmd.scan_step}) <= 1)
      else $error("overlapping table moves");

endmodule

// File: sv/segment_allocator_fit_policy.sv
// ----------------------------------------------------------------------------
// segment_allocator_fit_policy
// Segment table allocator with first, best and worst fit.
//
//  channel | ports                                   | dir
//  req     | req_valid req_stall req_opcode/owner_tag/request_size | in
//  rsp     | rsp_valid rsp_stall rsp_status rsp_granted_base       | out
//  csr     | csr_write csr_fit_policy                | in
//
// Alloc and free: an accept cycle, a scan of every table entry, then a decide
// step before the response. A split first moves each entry above the pick up
// by one, top first, then writes the split pair.
// Merge: steps or folds entry by entry, then responds.
// One item at a time; the next is taken once the response transfers.
// Synchronous reset leaves one free segment covering all memory, first fit.
// ----------------------------------------------------------------------------
module segment_allocator_fit_policy import sega_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_owner_tag,
   input  logic [10:0] req_request_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_granted_base,
   input  logic        csr_write,
   input  logic [1:0]  csr_fit_policy
);

   logic [1:0] pol_ff;
   cmd_type    cmd;
   stat_type   stat;

   // policy register
   always_ff @(posedge clock) begin
      if (reset) pol_ff <= POL_FIRST;
      else if (csr_write) pol_ff <= csr_fit_policy;
   end

   sega_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_opcode,
      .pol(pol_ff), .req_size(req_request_size),
      .rsp_valid, .rsp_stall, .stat, .cmd
   );

   sega_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .opcode(req_opcode), .owner_tag(req_owner_tag),
      .request_size(req_request_size), .fit_policy(pol_ff),
      .status(rsp_status), .granted_base(rsp_granted_base)
   );

endmodule
